// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define BMF_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: assertion failed");
`define BMF_ASSERT_ALWAYS(name, clk, prop) \
   name: assert property (@(posedge clk) prop) \
      else $error("%m: assertion failed");
`else
`define BMF_ASSERT(name, clk, rst, prop)
`define BMF_ASSERT_ALWAYS(name, clk, prop)
`endif

`endif

// ===== rtl/bmf_pkg.sv =====
// ----------------------------------------------------------------------
// Box mean filter package
// Shared constants, register indexes and controller/datapath structs.
// ----------------------------------------------------------------------
`default_nettype none

package bmf_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int MAX_HEIGHT = 1024;
   localparam int HEIGHT_W   = 11;
   localparam int CSR_DATA_W = 11;
   localparam int CSR_IDX_W  = 2;
   localparam int ROW_OUT_W  = 10;
   localparam int COL_OUT_W  = 10;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS       = 2'd2;

   localparam logic [CSR_DATA_W-1:0] FRAME_WIDTH_RST  = 11'd1024;
   localparam logic [CSR_DATA_W-1:0] FRAME_HEIGHT_RST = 11'd1024;
   localparam logic [2:0]            RADIUS_RST       = 3'd4;

   typedef struct packed {
      logic accept;
      logic setup;
      logic scan;
      logic div_start;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic emit;
      logic scan_last;
      logic div_done;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

// ===== rtl/bmf_divider.sv =====
// ----------------------------------------------------------------------
// Box mean filter divider
// Signed by unsigned restoring divider, one quotient bit per cycle,
// quotient truncated toward zero.
// ----------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module bmf_divider #(
   parameter int DIVIDEND_W = 23,
   parameter int DIVISOR_W  = 7
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start_i,
   input  wire logic signed [DIVIDEND_W-1:0] dividend_i,
   input  wire logic        [DIVISOR_W-1:0]  divisor_i,
   output logic                              done_o,
   output logic signed [bmf_pkg::SAMPLE_W-1:0] quotient_o
);

   localparam int STEP_W = $clog2(DIVIDEND_W);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [DIVIDEND_W-1:0] work_ff, work_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  divisor_ff, divisor_in;
   logic                  neg_ff, neg_in;

   logic [DIVIDEND_W-1:0] magnitude;
   logic [DIVISOR_W:0]    trial;
   logic                  fits;
   logic [DIVIDEND_W-1:0] signed_quo;

   always_comb begin
      magnitude  = dividend_i[DIVIDEND_W-1] ? (~dividend_i + 1'b1) : dividend_i;
      trial      = {rem_ff, work_ff[DIVIDEND_W-1]};
      fits       = trial >= {1'b0, divisor_ff};
      busy_in    = busy_ff;
      done_in    = 1'b0;
      step_in    = step_ff;
      work_in    = work_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      neg_in     = neg_ff;
      if (start_i) begin
         busy_in    = 1'b1;
         step_in    = '0;
         work_in    = magnitude;
         rem_in     = '0;
         divisor_in = divisor_i;
         neg_in     = dividend_i[DIVIDEND_W-1];
      end else if (busy_ff) begin
         work_in = {work_ff[DIVIDEND_W-2:0], fits};
         rem_in  = fits ? DIVISOR_W'(trial - {1'b0, divisor_ff}) : trial[DIVISOR_W-1:0];
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(DIVIDEND_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
      signed_quo = neg_ff ? (~work_ff + 1'b1) : work_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff    <= step_in;
      work_ff    <= work_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      neg_ff     <= neg_in;
   end

   assign done_o     = done_ff;
   assign quotient_o = signed_quo[bmf_pkg::SAMPLE_W-1:0];

   `BMF_ASSERT(a_no_restart_busy, clock, reset, start_i |-> !busy_ff)

endmodule

`default_nettype wire

// ===== rtl/bmf_datapath.sv =====
// ----------------------------------------------------------------------
// Box mean filter datapath
// Position tracking, line store, window scan, accumulator, divider
// and result register.
// ----------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module bmf_datapath #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_RADIUS = 4
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire bmf_pkg::cmd_type                        cmd,
   output bmf_pkg::status_type                          status,
   input  wire logic [$clog2(MAX_WIDTH+1)-1:0]          frame_w,
   input  wire logic [bmf_pkg::HEIGHT_W-1:0]            frame_h,
   input  wire logic [$clog2(MAX_RADIUS+1)-1:0]         radius,
   input  wire logic signed [bmf_pkg::SAMPLE_W-1:0]     sample,
   input  wire logic                                    frame_start,
   input  wire logic                                    out_stall,
   output logic                                         out_valid,
   output logic signed [bmf_pkg::SAMPLE_W-1:0]          out_average,
   output logic [bmf_pkg::ROW_OUT_W-1:0]                out_row,
   output logic [bmf_pkg::COL_OUT_W-1:0]                out_col,
   output logic                                         out_frame_done
);

   localparam int STORE_ROWS = 2 * MAX_RADIUS + 1;
   localparam int WIN_MAX    = STORE_ROWS * STORE_ROWS;
   localparam int SLOT_W     = $clog2(STORE_ROWS);
   localparam int CW         = $clog2(MAX_WIDTH + MAX_RADIUS + 1);
   localparam int RW         = $clog2(bmf_pkg::MAX_HEIGHT + MAX_RADIUS + 1);
   localparam int CIDX       = $clog2(MAX_WIDTH);
   localparam int CNT_W      = $clog2(WIN_MAX + 1);
   localparam int SUM_W      = bmf_pkg::SAMPLE_W + $clog2(WIN_MAX);

   logic signed [bmf_pkg::SAMPLE_W-1:0] store_mem [STORE_ROWS][MAX_WIDTH];

   logic [RW-1:0]     row_pos_ff, row_pos_in;
   logic [CW-1:0]     col_pos_ff, col_pos_in;
   logic [SLOT_W-1:0] row_slot_ff, row_slot_in;
   logic              emit_ff, emit_in;
   logic              rd_valid_ff;
   logic              rsp_valid_ff, rsp_valid_in;

   logic [RW-1:0]     cur_r_ff, cur_r_in;
   logic [CW-1:0]     cur_c_ff, cur_c_in;
   logic [SLOT_W-1:0] cur_slot_ff, cur_slot_in;
   logic [RW-1:0]     k_ff, k_in, k_end_ff, k_end_in;
   logic [CW-1:0]     l_ff, l_in, l_start_ff, l_start_in, l_end_ff, l_end_in;
   logic [SLOT_W-1:0] kslot_ff, kslot_in;
   logic signed [bmf_pkg::SAMPLE_W-1:0] rd_data_ff;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [bmf_pkg::ROW_OUT_W-1:0] pix_row_ff, pix_row_in;
   logic [bmf_pkg::COL_OUT_W-1:0] pix_col_ff, pix_col_in;
   logic              pix_done_ff, pix_done_in;
   logic signed [bmf_pkg::SAMPLE_W-1:0] avg_ff, avg_in;
   logic [bmf_pkg::ROW_OUT_W-1:0] row_out_ff, row_out_in;
   logic [bmf_pkg::COL_OUT_W-1:0] col_out_ff, col_out_in;
   logic              done_out_ff, done_out_in;

   logic [CW-1:0]     ww, rad_c, ext_w, acc_c, c_inc, two_rad_c, l0, l1, pc;
   logic [RW-1:0]     hh, rad_r, ext_h, acc_r, r_inc, two_rad_r, k0, k1, pr;
   logic [SLOT_W-1:0] acc_slot, back, kslot0;
   logic              restart, store_we, acc_emit, scan_last;
   logic              div_done;
   logic signed [bmf_pkg::SAMPLE_W-1:0] quotient;

   always_comb begin
      ww        = CW'(frame_w);
      hh        = RW'(frame_h);
      rad_c     = CW'(radius);
      rad_r     = RW'(radius);
      ext_w     = ww + rad_c;
      ext_h     = hh + rad_r;
      two_rad_c = rad_c << 1;
      two_rad_r = rad_r << 1;

      restart  = frame_start || (row_pos_ff >= ext_h) || (col_pos_ff >= ext_w);
      acc_r    = restart ? '0 : row_pos_ff;
      acc_c    = restart ? '0 : col_pos_ff;
      acc_slot = restart ? '0 : row_slot_ff;
      store_we = cmd.accept && (acc_r < hh) && (acc_c < ww);
      acc_emit = (acc_r >= rad_r) && (acc_c >= rad_c);
      c_inc    = acc_c + CW'(1);
      r_inc    = acc_r + RW'(1);

      k0     = (cur_r_ff >= two_rad_r) ? cur_r_ff - two_rad_r : '0;
      k1     = (cur_r_ff < hh) ? cur_r_ff : hh - RW'(1);
      l0     = (cur_c_ff >= two_rad_c) ? cur_c_ff - two_rad_c : '0;
      l1     = (cur_c_ff < ww) ? cur_c_ff : ww - CW'(1);
      back   = SLOT_W'(cur_r_ff - k0);
      kslot0 = (cur_slot_ff >= back) ? cur_slot_ff - back
                                     : cur_slot_ff + (SLOT_W'(STORE_ROWS) - back);
      pr     = cur_r_ff - rad_r;
      pc     = cur_c_ff - rad_c;

      scan_last = (l_ff == l_end_ff) && (k_ff == k_end_ff);
   end

   always_comb begin
      row_pos_in   = row_pos_ff;
      col_pos_in   = col_pos_ff;
      row_slot_in  = row_slot_ff;
      emit_in      = emit_ff;
      cur_r_in     = cur_r_ff;
      cur_c_in     = cur_c_ff;
      cur_slot_in  = cur_slot_ff;
      k_in         = k_ff;
      k_end_in     = k_end_ff;
      l_in         = l_ff;
      l_start_in   = l_start_ff;
      l_end_in     = l_end_ff;
      kslot_in     = kslot_ff;
      sum_in       = sum_ff;
      cnt_in       = cnt_ff;
      pix_row_in   = pix_row_ff;
      pix_col_in   = pix_col_ff;
      pix_done_in  = pix_done_ff;
      avg_in       = avg_ff;
      row_out_in   = row_out_ff;
      col_out_in   = col_out_ff;
      done_out_in  = done_out_ff;
      rsp_valid_in = rsp_valid_ff;

      if (cmd.accept) begin
         cur_r_in    = acc_r;
         cur_c_in    = acc_c;
         cur_slot_in = acc_slot;
         emit_in     = acc_emit;
         if (c_inc >= ext_w) begin
            col_pos_in = '0;
            if (r_inc >= ext_h) begin
               row_pos_in  = '0;
               row_slot_in = '0;
            end else begin
               row_pos_in  = r_inc;
               row_slot_in = (acc_slot == SLOT_W'(STORE_ROWS - 1)) ? '0
                                                                   : acc_slot + SLOT_W'(1);
            end
         end else begin
            col_pos_in  = c_inc;
            row_pos_in  = acc_r;
            row_slot_in = acc_slot;
         end
      end

      if (cmd.setup) begin
         k_in        = k0;
         k_end_in    = k1;
         l_in        = l0;
         l_start_in  = l0;
         l_end_in    = l1;
         kslot_in    = kslot0;
         sum_in      = '0;
         cnt_in      = '0;
         pix_row_in  = bmf_pkg::ROW_OUT_W'(pr);
         pix_col_in  = bmf_pkg::COL_OUT_W'(pc);
         pix_done_in = (pr == hh - RW'(1)) && (pc == ww - CW'(1));
      end

      if (cmd.scan) begin
         cnt_in = cnt_ff + CNT_W'(1);
         if (l_ff == l_end_ff) begin
            l_in     = l_start_ff;
            k_in     = k_ff + RW'(1);
            kslot_in = (kslot_ff == SLOT_W'(STORE_ROWS - 1)) ? '0 : kslot_ff + SLOT_W'(1);
         end else begin
            l_in = l_ff + CW'(1);
         end
      end

      if (rd_valid_ff) begin
         sum_in = sum_ff + SUM_W'(rd_data_ff);
      end

      if (rsp_valid_ff && !out_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
         avg_in       = quotient;
         row_out_in   = pix_row_ff;
         col_out_in   = pix_col_ff;
         done_out_in  = pix_done_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (store_we) begin
         store_mem[acc_slot][acc_c[CIDX-1:0]] <= sample;
      end
      if (cmd.scan) begin
         rd_data_ff <= store_mem[kslot_ff][l_ff[CIDX-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_pos_ff   <= '0;
         col_pos_ff   <= '0;
         row_slot_ff  <= '0;
         emit_ff      <= 1'b0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         row_pos_ff   <= row_pos_in;
         col_pos_ff   <= col_pos_in;
         row_slot_ff  <= row_slot_in;
         emit_ff      <= emit_in;
         rd_valid_ff  <= cmd.scan;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_r_ff    <= cur_r_in;
      cur_c_ff    <= cur_c_in;
      cur_slot_ff <= cur_slot_in;
      k_ff        <= k_in;
      k_end_ff    <= k_end_in;
      l_ff        <= l_in;
      l_start_ff  <= l_start_in;
      l_end_ff    <= l_end_in;
      kslot_ff    <= kslot_in;
      sum_ff      <= sum_in;
      cnt_ff      <= cnt_in;
      pix_row_ff  <= pix_row_in;
      pix_col_ff  <= pix_col_in;
      pix_done_ff <= pix_done_in;
      avg_ff      <= avg_in;
      row_out_ff  <= row_out_in;
      col_out_ff  <= col_out_in;
      done_out_ff <= done_out_in;
   end

   bmf_divider #(
      .DIVIDEND_W (SUM_W),
      .DIVISOR_W  (CNT_W)
   ) u_divider (
      .clock      (clock),
      .reset      (reset),
      .start_i    (cmd.div_start),
      .dividend_i (sum_ff),
      .divisor_i  (cnt_ff),
      .done_o     (div_done),
      .quotient_o (quotient)
   );

   always_comb begin
      status.emit      = emit_ff;
      status.scan_last = scan_last;
      status.div_done  = div_done;
      status.out_free  = !rsp_valid_ff || !out_stall;
   end

   assign out_valid      = rsp_valid_ff;
   assign out_average    = avg_ff;
   assign out_row        = row_out_ff;
   assign out_col        = col_out_ff;
   assign out_frame_done = done_out_ff;

   `BMF_ASSERT(a_scan_within_window, clock, reset, cmd.scan |-> cnt_ff < CNT_W'(WIN_MAX))
   `BMF_ASSERT(a_sum_settled_at_divide, clock, reset, cmd.div_start |-> !rd_valid_ff)

endmodule

`default_nettype wire

// ===== rtl/bmf_ctrl.sv =====
// ----------------------------------------------------------------------
// Box mean filter controller
// Sequences accept, window setup, window scan, divide and result load.
// ----------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module bmf_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire bmf_pkg::status_type status,
   output bmf_pkg::cmd_type         cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_SCAN,
      ST_DRAIN,
      ST_DIV_LOAD,
      ST_DIV_RUN,
      ST_RESULT
   } state_type;

   state_type state_ff, state_in;
   logic      stall_ff, stall_in;

   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && !stall_ff) begin
               cmd.accept = 1'b1;
               state_in   = ST_SETUP;
            end
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
            state_in  = status.emit ? ST_SCAN : ST_IDLE;
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DIV_LOAD;
         end
         ST_DIV_LOAD: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV_RUN;
         end
         ST_DIV_RUN: begin
            if (status.div_done) begin
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      stall_in = (state_in != ST_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         stall_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         stall_ff <= stall_in;
      end
   end

   assign req_stall = stall_ff;

   `BMF_ASSERT(a_div_done_when_waiting, clock, reset, status.div_done |-> state_ff == ST_DIV_RUN)

endmodule

`default_nettype wire

// ===== rtl/box_mean_filter_2d_unit.sv =====
// ----------------------------------------------------------------------
// Box mean filter 2D unit
// Mean over a square window of in-frame cells, samples in raster order
// over a grid padded by radius rows and columns.
// ----------------------------------------------------------------------
//  channel  direction  handshake          payload
//  req      in         req_valid/stall    sample, frame_start
//  rsp      out        rsp_valid/stall    average, out_row, out_col, frame_done
//  csr      in         csr_valid/ready    csr_index, csr_data
//
//  An item with no result returns to idle after window setup; an item
//  with a result also reads its n in-frame window cells (up to 81) from
//  the single read port of the line store and then runs the
//  one-bit-per-cycle divider, DW bits wide (23 at defaults).
//  Reset is synchronous; req_stall is high for one cycle after it.
//  A finished result waits in the output register while the next
//  request is taken; csr_ready is always high.
// ----------------------------------------------------------------------
`default_nettype none

module box_mean_filter_2d_unit #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_RADIUS = 4
) (
   input  wire logic                                       clock,
   input  wire logic                                       reset,
   input  wire logic                                       req_valid,
   output logic                                            req_stall,
   input  wire logic signed [bmf_pkg::SAMPLE_W-1:0]        req_sample,
   input  wire logic                                       req_frame_start,
   output logic                                            rsp_valid,
   input  wire logic                                       rsp_stall,
   output logic signed [bmf_pkg::SAMPLE_W-1:0]             rsp_average,
   output logic [bmf_pkg::ROW_OUT_W-1:0]                   rsp_out_row,
   output logic [bmf_pkg::COL_OUT_W-1:0]                   rsp_out_col,
   output logic                                            rsp_frame_done,
   input  wire logic                                       csr_valid,
   output logic                                            csr_ready,
   input  wire logic [bmf_pkg::CSR_IDX_W-1:0]              csr_index,
   input  wire logic [bmf_pkg::CSR_DATA_W-1:0]             csr_data
);

   localparam int WCFG_W = $clog2(MAX_WIDTH + 1);
   localparam int RAD_W  = $clog2(MAX_RADIUS + 1);

   logic [bmf_pkg::CSR_DATA_W-1:0] frame_width_ff, frame_width_in;
   logic [bmf_pkg::CSR_DATA_W-1:0] frame_height_ff, frame_height_in;
   logic [2:0]                     radius_ff, radius_in;

   logic [WCFG_W-1:0]            eff_w;
   logic [bmf_pkg::HEIGHT_W-1:0] eff_h;
   logic [RAD_W-1:0]             eff_rad;

   bmf_pkg::cmd_type    cmd;
   bmf_pkg::status_type status;

   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      radius_in       = radius_ff;
      if (csr_valid) begin
         case (csr_index)
            bmf_pkg::CSR_FRAME_WIDTH:  frame_width_in  = csr_data;
            bmf_pkg::CSR_FRAME_HEIGHT: frame_height_in = csr_data;
            bmf_pkg::CSR_RADIUS:       radius_in       = csr_data[2:0];
            default: begin
            end
         endcase
      end

      if (frame_width_ff == '0) begin
         eff_w = WCFG_W'(1);
      end else if (32'(frame_width_ff) > MAX_WIDTH) begin
         eff_w = WCFG_W'(MAX_WIDTH);
      end else begin
         eff_w = WCFG_W'(frame_width_ff);
      end

      if (frame_height_ff == '0) begin
         eff_h = bmf_pkg::HEIGHT_W'(1);
      end else if (32'(frame_height_ff) > bmf_pkg::MAX_HEIGHT) begin
         eff_h = bmf_pkg::HEIGHT_W'(bmf_pkg::MAX_HEIGHT);
      end else begin
         eff_h = bmf_pkg::HEIGHT_W'(frame_height_ff);
      end

      if (32'(radius_ff) > MAX_RADIUS) begin
         eff_rad = RAD_W'(MAX_RADIUS);
      end else begin
         eff_rad = RAD_W'(radius_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= bmf_pkg::FRAME_WIDTH_RST;
         frame_height_ff <= bmf_pkg::FRAME_HEIGHT_RST;
         radius_ff       <= bmf_pkg::RADIUS_RST;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
         radius_ff       <= radius_in;
      end
   end

   assign csr_ready = 1'b1;

   bmf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   bmf_datapath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_RADIUS (MAX_RADIUS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .frame_w        (eff_w),
      .frame_h        (eff_h),
      .radius         (eff_rad),
      .sample         (req_sample),
      .frame_start    (req_frame_start),
      .out_stall      (rsp_stall),
      .out_valid      (rsp_valid),
      .out_average    (rsp_average),
      .out_row        (rsp_out_row),
      .out_col        (rsp_out_col),
      .out_frame_done (rsp_frame_done)
   );

endmodule

`default_nettype wire
